/* src/dns_ttl_cache_table_macros.svh */
// assertion macros for the dns ttl cache table
`ifndef DNS_TTL_CACHE_TABLE_MACROS_SVH
`define DNS_TTL_CACHE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define DTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define DTC_ASSERT(label, prop, msg)
`define DTC_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* src/dtc_pkg.sv */
// shared types and constants of the dns ttl cache table
`timescale 1ns / 1ps
package dtc_pkg;
    localparam int ENTRIES    = 16;
    localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam int FUNC_W     = 2;
    localparam int KEY_W      = 64;
    localparam int QTYPE_W    = 16;
    localparam int TIME_W     = 32;
    localparam int TTL_W      = 32;
    localparam int LEN_W      = 16;
    localparam int RCODE_W    = 4;
    localparam int MAX_TTL_W  = 23;
    localparam int MS_W       = 10;
    localparam int PROD_W     = MAX_TTL_W + MS_W;
    localparam int OUT_SLOT_W = 4;
    localparam int OUT_CNT_W  = 5;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_MAX_TTL = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NEG_TTL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = 2'd2;

    localparam logic [MAX_TTL_W-1:0] MAX_TTL_RESET = 23'd3600;
    localparam logic [TIME_W-1:0]    NEG_TTL_RESET = 32'd60000;
    localparam logic [LEN_W-1:0]     MAX_LEN_RESET = 16'd512;

    localparam logic [RCODE_W-1:0] RCODE_SERVFAIL = 4'd2;
    localparam logic [LEN_W-1:0]   RCODE_MIN_LEN  = 16'd4;
    localparam logic [MS_W-1:0]    MS_PER_SEC     = 10'd1000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP     = 2'd0,
        FUNC_INSERT     = 2'd1,
        FUNC_INSERT_NEG = 2'd2,
        FUNC_FLUSH      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_MUL,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [MAX_TTL_W-1:0] max_ttl_secs;
        logic [TIME_W-1:0]    neg_ttl_ms;
        logic [LEN_W-1:0]     max_response_len;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [QTYPE_W-1:0] qtype;
        logic [TIME_W-1:0]  expiry;
        logic [LEN_W-1:0]   len;
    } entry_t;
endpackage

/* src/dtc_req_if.sv */
// request channel of the dns ttl cache table
`timescale 1ns / 1ps
interface dtc_req_if;
    logic                                valid;
    logic                                ready;
    logic [dtc_pkg::FUNC_W-1:0]          func;
    logic [dtc_pkg::KEY_W-1:0]           name_key;
    logic [dtc_pkg::QTYPE_W-1:0]         query_type;
    logic [dtc_pkg::TIME_W-1:0]          now_ms;
    logic [dtc_pkg::TTL_W-1:0]           ttl_secs;
    logic [dtc_pkg::LEN_W-1:0]           response_len;
    logic [dtc_pkg::RCODE_W-1:0]         response_rcode;

    modport source (
        output valid, func, name_key, query_type, now_ms, ttl_secs, response_len,
               response_rcode,
        input  ready
    );
    modport sink (
        input  valid, func, name_key, query_type, now_ms, ttl_secs, response_len,
               response_rcode,
        output ready
    );
endinterface

/* src/dtc_rsp_if.sv */
// result channel of the dns ttl cache table
`timescale 1ns / 1ps
interface dtc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [dtc_pkg::OUT_SLOT_W-1:0]    slot;
    logic [dtc_pkg::LEN_W-1:0]         stored_len;
    logic                              accepted;
    logic [dtc_pkg::OUT_CNT_W-1:0]     valid_count;

    modport source (
        output valid, hit, slot, stored_len, accepted, valid_count,
        input  ready
    );
    modport sink (
        input  valid, hit, slot, stored_len, accepted, valid_count,
        output ready
    );
endinterface

/* src/dtc_match_unit.sv */
// shared entry compare unit: digest, query type and expiry check
`timescale 1ns / 1ps
module dtc_match_unit (
    input  dtc_pkg::entry_t                entry,
    input  logic                           entry_valid,
    input  logic [dtc_pkg::KEY_W-1:0]      key,
    input  logic [dtc_pkg::QTYPE_W-1:0]    qtype,
    input  logic [dtc_pkg::TIME_W-1:0]     now,
    output logic                           match
);
    logic key_eq;
    logic qtype_eq;
    logic live;

    assign key_eq   = (entry.key == key);
    assign qtype_eq = (entry.qtype == qtype);
    // plain unsigned compare, wrapped expiries read as expired
    assign live     = (now < entry.expiry);
    assign match    = entry_valid && key_eq && qtype_eq && live;
endmodule

/* src/dtc_entry_mem.sv */
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module dtc_entry_mem (
    input  logic                          clk,
    input  logic                          we,
    input  logic [dtc_pkg::SLOT_W-1:0]    waddr,
    input  dtc_pkg::entry_t               wdata,
    input  logic                          re,
    input  logic [dtc_pkg::SLOT_W-1:0]    raddr,
    output dtc_pkg::entry_t               rdata
);
    dtc_pkg::entry_t mem [dtc_pkg::ENTRIES];
    dtc_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* src/dtc_cfg_regs.sv */
// apb configuration registers
`timescale 1ns / 1ps
module dtc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dtc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dtc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dtc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output dtc_pkg::cfg_t                     cfg
);
    dtc_pkg::cfg_t                    cfg_reg;
    dtc_pkg::cfg_t                    cfg_next;
    logic                             wr_en;
    logic [dtc_pkg::REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[dtc_pkg::APB_ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                dtc_pkg::REG_MAX_TTL:
                    cfg_next.max_ttl_secs = pwdata[dtc_pkg::MAX_TTL_W-1:0];
                dtc_pkg::REG_NEG_TTL:
                    cfg_next.neg_ttl_ms = pwdata[dtc_pkg::TIME_W-1:0];
                dtc_pkg::REG_MAX_LEN:
                    cfg_next.max_response_len = pwdata[dtc_pkg::LEN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dtc_pkg::REG_MAX_TTL:
                prdata = dtc_pkg::APB_DATA_W'(cfg_reg.max_ttl_secs);
            dtc_pkg::REG_NEG_TTL:
                prdata = dtc_pkg::APB_DATA_W'(cfg_reg.neg_ttl_ms);
            dtc_pkg::REG_MAX_LEN:
                prdata = dtc_pkg::APB_DATA_W'(cfg_reg.max_response_len);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_ttl_secs     <= dtc_pkg::MAX_TTL_RESET;
            cfg_reg.neg_ttl_ms       <= dtc_pkg::NEG_TTL_RESET;
            cfg_reg.max_response_len <= dtc_pkg::MAX_LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

/* src/dtc_ctrl.sv */
// sequencer: entry walk, insert, flush and result register
`timescale 1ns / 1ps
`include "dns_ttl_cache_table_macros.svh"
module dtc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  dtc_pkg::cfg_t    cfg,
    dtc_req_if.sink          req,
    dtc_rsp_if.source        rsp
);
    dtc_pkg::state_t                  state_reg;
    dtc_pkg::state_t                  state_next;

    dtc_pkg::func_t                   func_reg;
    logic [dtc_pkg::KEY_W-1:0]        key_reg;
    logic [dtc_pkg::QTYPE_W-1:0]      qtype_reg;
    logic [dtc_pkg::TIME_W-1:0]       now_reg;
    logic [dtc_pkg::LEN_W-1:0]        len_reg;
    logic [dtc_pkg::MAX_TTL_W-1:0]    ttl_reg;
    logic [dtc_pkg::TIME_W-1:0]       addend_reg;

    logic [dtc_pkg::ENTRIES-1:0]      valid_reg;
    logic [dtc_pkg::CNT_W-1:0]        count_reg;
    logic [dtc_pkg::SLOT_W-1:0]       next_slot_reg;
    logic [dtc_pkg::SLOT_W-1:0]       idx_reg;
    logic [dtc_pkg::SLOT_W-1:0]       cmp_idx_reg;
    logic                             cmp_live_reg;

    logic                             res_hit_reg;
    logic [dtc_pkg::SLOT_W-1:0]       res_slot_reg;
    logic [dtc_pkg::LEN_W-1:0]        res_len_reg;
    logic                             res_acc_reg;

    logic                             out_valid_reg;
    logic                             out_hit_reg;
    logic [dtc_pkg::SLOT_W-1:0]       out_slot_reg;
    logic [dtc_pkg::LEN_W-1:0]        out_len_reg;
    logic                             out_acc_reg;
    logic [dtc_pkg::CNT_W-1:0]        out_cnt_reg;

    dtc_pkg::func_t                   in_func;
    logic                             in_fire;
    logic                             ins_ok;
    logic [dtc_pkg::MAX_TTL_W-1:0]    ttl_clamped;
    logic [dtc_pkg::PROD_W-1:0]       ttl_prod;

    logic                             req_ready;
    logic                             look_en;
    logic                             mem_we;
    logic                             out_load;
    logic                             out_free;

    dtc_pkg::entry_t                  rd_entry;
    dtc_pkg::entry_t                  wr_entry;
    logic                             cmp_match;
    logic                             hit_now;
    logic                             walk_end;
    logic                             look_done;

    assign in_func  = dtc_pkg::func_t'(req.func);
    assign in_fire  = req.valid && req_ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign ins_ok = (req.response_len != '0)
                 && (req.response_len <= cfg.max_response_len)
                 && !((req.response_len >= dtc_pkg::RCODE_MIN_LEN)
                      && (req.response_rcode == dtc_pkg::RCODE_SERVFAIL));

    assign ttl_clamped = ((req.ttl_secs == '0)
                         || (req.ttl_secs > dtc_pkg::TTL_W'(cfg.max_ttl_secs)))
                         ? cfg.max_ttl_secs : req.ttl_secs[dtc_pkg::MAX_TTL_W-1:0];

    assign ttl_prod = dtc_pkg::PROD_W'(ttl_reg) * dtc_pkg::PROD_W'(dtc_pkg::MS_PER_SEC);

    dtc_entry_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (next_slot_reg),
        .wdata (wr_entry),
        .re    (look_en),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    dtc_match_unit u_match (
        .entry       (rd_entry),
        .entry_valid (valid_reg[cmp_idx_reg]),
        .key         (key_reg),
        .qtype       (qtype_reg),
        .now         (now_reg),
        .match       (cmp_match)
    );

    assign hit_now   = cmp_live_reg && cmp_match;
    assign walk_end  = cmp_live_reg && (cmp_idx_reg == dtc_pkg::SLOT_W'(dtc_pkg::ENTRIES - 1));
    assign look_done = hit_now || walk_end;

    always_comb
    begin
        wr_entry.key    = key_reg;
        wr_entry.qtype  = qtype_reg;
        wr_entry.expiry = now_reg + addend_reg;
        wr_entry.len    = (func_reg == dtc_pkg::FUNC_INSERT_NEG) ? '0 : len_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_func)
                        dtc_pkg::FUNC_LOOKUP:     state_next = dtc_pkg::ST_LOOK;
                        dtc_pkg::FUNC_INSERT:
                            state_next = ins_ok ? dtc_pkg::ST_MUL : dtc_pkg::ST_DONE;
                        dtc_pkg::FUNC_INSERT_NEG: state_next = dtc_pkg::ST_WRITE;
                        default:                  state_next = dtc_pkg::ST_DONE;
                    endcase
                end
            end
            dtc_pkg::ST_LOOK:
            begin
                if (look_done)
                begin
                    state_next = dtc_pkg::ST_DONE;
                end
            end
            dtc_pkg::ST_MUL:   state_next = dtc_pkg::ST_WRITE;
            dtc_pkg::ST_WRITE: state_next = dtc_pkg::ST_DONE;
            dtc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = dtc_pkg::ST_IDLE;
                end
            end
            default:           state_next = dtc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_ready = 1'b0;
        look_en   = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            dtc_pkg::ST_IDLE:  req_ready = 1'b1;
            dtc_pkg::ST_LOOK:  look_en   = !look_done;
            dtc_pkg::ST_MUL:   req_ready = 1'b0;
            dtc_pkg::ST_WRITE: mem_we    = 1'b1;
            dtc_pkg::ST_DONE:  out_load  = out_free;
            default:           req_ready = 1'b0;
        endcase
    end

    // item latch and working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg   <= in_func;
            key_reg    <= req.name_key;
            qtype_reg  <= req.query_type;
            now_reg    <= req.now_ms;
            len_reg    <= req.response_len;
            ttl_reg    <= ttl_clamped;
            addend_reg <= cfg.neg_ttl_ms;
        end
        else if (state_reg == dtc_pkg::ST_MUL)
        begin
            addend_reg <= ttl_prod[dtc_pkg::TIME_W-1:0];
        end
        cmp_idx_reg <= idx_reg;
        if (hit_now)
        begin
            res_len_reg <= rd_entry.len;
        end
        if (out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_slot_reg <= res_slot_reg;
            out_len_reg  <= res_hit_reg ? res_len_reg : '0;
            out_acc_reg  <= res_acc_reg;
            out_cnt_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtc_pkg::ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            next_slot_reg <= '0;
            idx_reg       <= '0;
            cmp_live_reg  <= 1'b0;
            res_hit_reg   <= 1'b0;
            res_slot_reg  <= '0;
            res_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmp_live_reg <= look_en;
            if (in_fire)
            begin
                idx_reg      <= '0;
                res_hit_reg  <= 1'b0;
                res_slot_reg <= '0;
                res_acc_reg  <= 1'b0;
                if (in_func == dtc_pkg::FUNC_FLUSH)
                begin
                    valid_reg <= '0;
                    count_reg <= '0;
                end
            end
            if (look_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (hit_now)
            begin
                res_hit_reg  <= 1'b1;
                res_slot_reg <= cmp_idx_reg;
            end
            if (mem_we)
            begin
                valid_reg[next_slot_reg] <= 1'b1;
                if (!valid_reg[next_slot_reg])
                begin
                    count_reg <= count_reg + 1'b1;
                end
                res_acc_reg  <= 1'b1;
                res_slot_reg <= next_slot_reg;
                next_slot_reg <= (next_slot_reg == dtc_pkg::SLOT_W'(dtc_pkg::ENTRIES - 1))
                                 ? '0 : next_slot_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign req.ready       = req_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.slot        = dtc_pkg::OUT_SLOT_W'(out_slot_reg);
    assign rsp.stored_len  = out_len_reg;
    assign rsp.accepted    = out_acc_reg;
    assign rsp.valid_count = dtc_pkg::OUT_CNT_W'(out_cnt_reg);

    `DTC_ASSERT(a_count_tracks_valid, count_reg == dtc_pkg::CNT_W'($countones(valid_reg)), "valid count out of step with valid bits")
    `DTC_ASSERT(a_hit_xor_write, !(out_valid_reg && out_hit_reg && out_acc_reg), "beat reports both a hit and a write")
    `DTC_ASSERT_NEXT(a_busy_after_accept, in_fire, !req_ready, "new beat taken while an item is in work")
    `DTC_ASSERT_NEXT(a_slot_advances, mem_we, next_slot_reg != $past(next_slot_reg), "round robin slot did not advance on write")
endmodule

/* src/dns_ttl_cache_table.sv */
// top level of the dns ttl cache table
// A table of ENTRIES cached name answers, each keyed by a 64-bit name digest and a
// query type and carrying an expiry in milliseconds. One request beat is taken at a
// time and gives exactly one result beat; the block is busy from acceptance until
// the result sits in its output register, which can still be waiting while the next
// request comes in. A lookup walks the entry memory one read per cycle through a
// single compare unit and stops at the first live match; an insert clamps the ttl at
// acceptance, multiplies it by 1000, writes and gives the result; a negative insert
// writes and gives the result; a refused insert or a flush goes straight to the
// result step, which waits while the previous result is still unaccepted.
// Registers sit on the apb port at byte addresses 0 (max ttl seconds), 4 (negative
// ttl milliseconds) and 8 (longest cacheable response); pready is always high.
`timescale 1ns / 1ps
module dns_ttl_cache_table (
    input  logic                              clk,
    input  logic                              rst_n,
    dtc_req_if.sink                           req,
    dtc_rsp_if.source                         rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dtc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dtc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dtc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    dtc_pkg::cfg_t cfg;

    dtc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );
endmodule

/* verif/dtc_answer_checker.sv */
// checker that predicts and compares the answers of the dns ttl cache table
`timescale 1ns / 1ps
module dtc_answer_checker
    import dtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dtc_req_if                    req,
    dtc_rsp_if                    rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    waiting,
    output int                    answers_checked,
    output int                    hits_seen
);

    typedef struct packed {
        logic                  hit;
        logic [OUT_SLOT_W-1:0] slot;
        logic [LEN_W-1:0]      stored_len;
        logic                  accepted;
        logic [OUT_CNT_W-1:0]  valid_count;
    } answer_t;

    cfg_t              cfg;
    logic              ent_valid [ENTRIES];
    entry_t            ent [ENTRIES];
    logic [SLOT_W-1:0] wr_ptr;
    answer_t           expected_answers [$];
    int                errors = 0;
    int                checked = 0;
    int                hits = 0;

    function automatic logic [OUT_CNT_W-1:0] live_entries();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ent_valid[i])
            begin
                n++;
            end
        end
        return OUT_CNT_W'(n);
    endfunction

    function automatic logic [SLOT_W-1:0] store_entry(
        input logic [KEY_W-1:0]   key,
        input logic [QTYPE_W-1:0] qt,
        input logic [TIME_W-1:0]  expiry,
        input logic [LEN_W-1:0]   len
    );
        logic [SLOT_W-1:0] s;
        s = wr_ptr;
        ent[s] = '{key, qt, expiry, len};
        ent_valid[s] = 1'b1;
        wr_ptr = (int'(wr_ptr) == ENTRIES - 1) ? '0 : wr_ptr + 1'b1;
        return s;
    endfunction

    function automatic answer_t predict_answer(
        input logic [FUNC_W-1:0]  f,
        input logic [KEY_W-1:0]   key,
        input logic [QTYPE_W-1:0] qt,
        input logic [TIME_W-1:0]  now,
        input logic [TTL_W-1:0]   ttl,
        input logic [LEN_W-1:0]   len,
        input logic [RCODE_W-1:0] rcode
    );
        answer_t          a;
        logic [TTL_W-1:0] life;
        logic             ok;
        a = '0;
        case (f)
            FUNC_LOOKUP:
            begin
                // first live match in index order wins
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!a.hit && ent_valid[i] && ent[i].key == key && ent[i].qtype == qt
                        && now < ent[i].expiry)
                    begin
                        a.hit        = 1'b1;
                        a.slot       = OUT_SLOT_W'(i);
                        a.stored_len = ent[i].len;
                    end
                end
            end
            FUNC_INSERT:
            begin
                ok = len != '0 && len <= cfg.max_response_len
                     && !(len >= RCODE_MIN_LEN && rcode == RCODE_SERVFAIL);
                if (ok)
                begin
                    life = ttl;
                    if (life == '0 || life > TTL_W'(cfg.max_ttl_secs))
                    begin
                        life = TTL_W'(cfg.max_ttl_secs);
                    end
                    a.slot = OUT_SLOT_W'(store_entry(key, qt,
                                                     now + life * TIME_W'(MS_PER_SEC), len));
                    a.accepted = 1'b1;
                end
            end
            FUNC_INSERT_NEG:
            begin
                a.slot     = OUT_SLOT_W'(store_entry(key, qt, now + cfg.neg_ttl_ms, '0));
                a.accepted = 1'b1;
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    ent_valid[i] = 1'b0;
                end
            end
        endcase
        a.valid_count = live_entries();
        return a;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            cfg = '{MAX_TTL_RESET, NEG_TTL_RESET, MAX_LEN_RESET};
            for (int i = 0; i < ENTRIES; i++)
            begin
                ent_valid[i] = 1'b0;
            end
            wr_ptr = '0;
            expected_answers.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: answer beat with nothing expected, expected none actual %0h",
                             $time, {rsp.hit, rsp.slot, rsp.stored_len, rsp.accepted,
                                     rsp.valid_count});
                end
                else
                begin
                    want = expected_answers.pop_front();
                    check_field("hit", want.hit, rsp.hit);
                    check_field("slot", want.slot, rsp.slot);
                    check_field("stored_len", want.stored_len, rsp.stored_len);
                    check_field("accepted", want.accepted, rsp.accepted);
                    check_field("valid_count", want.valid_count, rsp.valid_count);
                    checked++;
                    if (rsp.hit)
                    begin
                        hits++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_answers.push_back(predict_answer(req.func, req.name_key,
                    req.query_type, req.now_ms, req.ttl_secs, req.response_len,
                    req.response_rcode));
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_MAX_TTL: cfg.max_ttl_secs     = pwdata[MAX_TTL_W-1:0];
                    REG_NEG_TTL: cfg.neg_ttl_ms       = pwdata[TIME_W-1:0];
                    REG_MAX_LEN: cfg.max_response_len = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count      <= errors;
        waiting         <= expected_answers.size();
        answers_checked <= checked;
        hits_seen       <= hits;
    end

endmodule

/* verif/dns_ttl_cache_table_tb.sv */
// top of the dns ttl cache table testbench: stimulus, register setup and verdict
`timescale 1ns / 1ps
module dns_ttl_cache_table_tb;
    import dtc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = ENTRIES + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int KEY_POOL     = 6;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ZERO  = 64'h0;
    localparam logic [KEY_W-1:0] KEY_MIXED = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] KEY_NEG   = 64'hFEDC_BA98_7654_3210;
    localparam logic [KEY_W-1:0] KEY_WRAP  = 64'h8000_0000_0000_0001;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int waiting;
    int answers_checked;
    int hits_seen;
    int cycles = 0;
    int requests_sent = 0;
    int settings_used = 1;

    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_answers = 1'b0;

    logic [KEY_W-1:0]     key_pool [KEY_POOL];
    logic [QTYPE_W-1:0]   qtype_pool [KEY_POOL];
    logic [TIME_W-1:0]    clock_ms;
    logic [MAX_TTL_W-1:0] cur_max_ttl = MAX_TTL_RESET;
    logic [LEN_W-1:0]     cur_max_len = MAX_LEN_RESET;

    dtc_req_if req ();
    dtc_rsp_if rsp ();

    dns_ttl_cache_table uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dtc_answer_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .waiting         (waiting),
        .answers_checked (answers_checked),
        .hits_seen       (hits_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(
        input logic [MAX_TTL_W-1:0] max_ttl,
        input logic [TIME_W-1:0]    neg_ttl,
        input logic [LEN_W-1:0]     max_len
    );
        write_reg(REG_MAX_TTL, APB_DATA_W'(max_ttl));
        write_reg(REG_NEG_TTL, neg_ttl);
        write_reg(REG_MAX_LEN, APB_DATA_W'(max_len));
        cur_max_ttl = max_ttl;
        cur_max_len = max_len;
        settings_used++;
    endtask

    task automatic send_item(
        input func_t              f,
        input logic [KEY_W-1:0]   key,
        input logic [QTYPE_W-1:0] qt,
        input logic [TIME_W-1:0]  now,
        input logic [TTL_W-1:0]   ttl,
        input logic [LEN_W-1:0]   len,
        input logic [RCODE_W-1:0] rcode
    );
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req.func           <= f;
        req.name_key       <= key;
        req.query_type     <= qt;
        req.now_ms         <= now;
        req.ttl_secs       <= ttl;
        req.response_len   <= len;
        req.response_rcode <= rcode;
        req.valid          <= 1'b1;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic lookup_at(
        input logic [KEY_W-1:0]   key,
        input logic [QTYPE_W-1:0] qt,
        input logic [TIME_W-1:0]  now
    );
        send_item(FUNC_LOOKUP, key, qt, now, $urandom, LEN_W'($urandom), RCODE_W'($urandom));
    endtask

    task automatic insert_at(
        input logic [KEY_W-1:0]   key,
        input logic [QTYPE_W-1:0] qt,
        input logic [TIME_W-1:0]  now,
        input logic [TTL_W-1:0]   ttl,
        input logic [LEN_W-1:0]   len,
        input logic [RCODE_W-1:0] rcode
    );
        send_item(FUNC_INSERT, key, qt, now, ttl, len, rcode);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic directed_items();
        lookup_at(KEY_ZERO, 16'h0000, 32'd0);
        insert_at(KEY_ONES, 16'hFFFF, 32'd0, 32'd0, 16'd1, 4'd0);
        lookup_at(KEY_ONES, 16'hFFFF, 32'd100);
        lookup_at(KEY_ONES, 16'h0001, 32'd100);
        insert_at(KEY_MIXED, 16'h0001, 32'd10, 32'd30, 16'd0, 4'd0);
        insert_at(KEY_MIXED, 16'h0001, 32'd10, 32'd30, MAX_LEN_RESET + 16'd1, 4'd0);
        insert_at(KEY_ZERO, 16'h0000, 32'd0, 32'hFFFF_FFFF, MAX_LEN_RESET, 4'hF);
        insert_at(KEY_MIXED, 16'h001C, 32'd20, 32'd30, RCODE_MIN_LEN, RCODE_SERVFAIL);
        insert_at(KEY_MIXED, 16'h001C, 32'd20, 32'd30, RCODE_MIN_LEN - 16'd1, RCODE_SERVFAIL);
        insert_at(KEY_MIXED, 16'h001C, 32'd20, 32'd30, 16'hFFFF, 4'hF);
        send_item(FUNC_INSERT_NEG, KEY_NEG, 16'h0005, 32'd1000, 32'd7, 16'd9, 4'd3);
        lookup_at(KEY_NEG, 16'h0005, 32'd1000);
        lookup_at(KEY_NEG, 16'h0005, 32'd60999);
        lookup_at(KEY_NEG, 16'h0005, 32'd61000);
        insert_at(KEY_ONES, 16'hFFFF, 32'd2000, 32'd5, 16'd40, 4'd0);
        lookup_at(KEY_ONES, 16'hFFFF, 32'd2000);
        // expiry wraps past zero, so it reads as already expired
        insert_at(KEY_WRAP, 16'h00FF, 32'hFFFF_FC00, 32'd10, 16'd64, 4'd1);
        lookup_at(KEY_WRAP, 16'h00FF, 32'hFFFF_FC10);
        lookup_at(KEY_ZERO, 16'h0000, 32'd3599999);
        lookup_at(KEY_ZERO, 16'h0000, 32'd3600000);
        send_item(FUNC_FLUSH, KEY_ONES, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
        lookup_at(KEY_ONES, 16'hFFFF, 32'd2100);
        insert_at(KEY_ONES, 16'hFFFF, 32'd0, 32'd1, 16'd100, 4'd0);
        lookup_at(KEY_ONES, 16'hFFFF, 32'd999);
        drain();
    endtask

    task automatic random_item();
        int                 roll;
        int                 pick;
        func_t              f;
        logic [KEY_W-1:0]   key;
        logic [QTYPE_W-1:0] qt;
        logic [TTL_W-1:0]   ttl;
        logic [LEN_W-1:0]   len;
        logic [RCODE_W-1:0] rcode;
        pick = $urandom_range(0, KEY_POOL - 1);
        roll = $urandom_range(0, 99);
        f = (roll < 45) ? FUNC_LOOKUP : (roll < 78) ? FUNC_INSERT :
            (roll < 96) ? FUNC_INSERT_NEG : FUNC_FLUSH;
        key = key_pool[pick];
        qt  = qtype_pool[pick];
        if ($urandom_range(0, 9) == 0)
        begin
            key = {$urandom, $urandom};
        end
        if ($urandom_range(0, 9) == 0)
        begin
            qt = QTYPE_W'($urandom);
        end
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 1500));
        end
        else if (roll < 95)
        begin
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 200000));
        end
        else
        begin
            clock_ms = $urandom;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            ttl = TTL_W'($urandom_range(1, 20));
        end
        else if (roll < 70)
        begin
            ttl = '0;
        end
        else if (roll < 80)
        begin
            ttl = $urandom;
        end
        else if (roll < 90)
        begin
            // around the clamp boundary
            ttl = TTL_W'(cur_max_ttl) + TTL_W'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            ttl = TTL_W'($urandom_range(1, 600));
        end
        roll = $urandom_range(0, 99);
        if (roll < 75)
        begin
            len = LEN_W'($urandom_range(1, int'(cur_max_len)));
        end
        else if (roll < 82)
        begin
            len = '0;
        end
        else if (roll < 90 && cur_max_len != 16'hFFFF)
        begin
            len = cur_max_len + 16'd1;
        end
        else
        begin
            len = LEN_W'($urandom);
        end
        rcode = ($urandom_range(0, 4) == 0) ? RCODE_SERVFAIL : RCODE_W'($urandom_range(0, 15));
        send_item(f, key, qt, clock_ms, ttl, len, rcode);
    endtask

    task automatic run_phase(input int count, input bit idles, input bit pressure);
        sender_idles   = idles;
        receiver_idles = idles;
        if (pressure)
        begin
            hold_answers = 1'b1;
        end
        repeat (count)
        begin
            if (idles && $urandom_range(0, 24) == 0)
            begin
                sender_idles = !sender_idles;
            end
            if (idles && $urandom_range(0, 24) == 0)
            begin
                receiver_idles = !receiver_idles;
            end
            random_item();
        end
        drain();
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        rsp.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_answers)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp.ready <= 1'b1;
                hold_answers = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        req.valid          <= 1'b0;
        req.func           <= FUNC_LOOKUP;
        req.name_key       <= '0;
        req.query_type     <= '0;
        req.now_ms         <= '0;
        req.ttl_secs       <= '0;
        req.response_len   <= '0;
        req.response_rcode <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            key_pool[i]   = {$urandom, $urandom};
            qtype_pool[i] = QTYPE_W'($urandom_range(0, 3));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        clock_ms = '0;
        run_phase(120, 1'b1, 1'b0);

        configure(23'd1, 32'd0, 16'd1);
        run_phase(100, 1'b1, 1'b1);

        configure(23'd4294967, 32'hFFFF_FFFF, 16'hFFFF);
        run_phase(100, 1'b1, 1'b0);

        configure(MAX_TTL_W'($urandom_range(1, 120)), TIME_W'($urandom_range(0, 30000)),
                  LEN_W'($urandom_range(1, 2000)));
        write_reg(REG_UNUSED, $urandom);
        run_phase(140, 1'b1, 1'b0);

        configure(MAX_TTL_RESET, NEG_TTL_RESET, MAX_LEN_RESET);
        run_phase(140, 1'b0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d requests sent, %0d answers checked, %0d lookup hits",
                 requests_sent, answers_checked, hits_seen);
        $display("summary: %0d register settings incl. both range extremes, one long stall",
                 settings_used);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
